// ===== sv/sorted_timer_event_queue_core_defines.svh =====
// Assertion macros for the sorted timer event queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_CORE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define STQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/stq_pkg.sv =====
// Shared constants and types of the sorted timer event queue.
package stq_pkg;

    // command codes (input tuser)
    localparam logic [2:0] CMD_ADVANCE = 3'd0;
    localparam logic [2:0] CMD_SET_REL = 3'd1;
    localparam logic [2:0] CMD_SET_ABS = 3'd2;
    localparam logic [2:0] CMD_CANCEL  = 3'd3;
    localparam logic [2:0] CMD_RUN     = 3'd4;

    // result kinds (output tuser)
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EVENT   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam int TIME_W   = 64;
    localparam int TAG_W    = 32;
    localparam int ORDER_W  = 32;
    localparam int AMOUNT_W = 32;
    localparam int HANDLE_W = 4;

    // slot memory word: deadline lowest, then tag, then insertion order
    localparam int SLOT_W = TIME_W + TAG_W + ORDER_W;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 104;

    // one result word
    typedef struct packed {
        logic [1:0]          kind;
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   wait_usec;
        logic                last;
    } res_t;

endpackage

// ===== sv/sorted_timer_event_queue_core.sv =====
// Top level of the sorted timer event queue: control, slot scan and result register.
//
// A table of TIMERS pending timers keyed by a 64-bit microsecond deadline.
// Deadline, tag and insertion order of each slot live in one RAM with a
// registered read; the slot valid bits are flip-flops cleared at reset, so
// no clearing pass is needed. One command word is taken at a time.
// Advance, cancel and unused codes go straight to the output step. A set
// walks the valid bits one slot a cycle for the lowest free slot, through
// every slot when the table is full. A run makes one full pass over the RAM
// per result (a read of every slot, a decide step, an output step), so a
// run that fires k timers makes k + 1 passes; the single RAM read port
// forces a fresh pass for each result.
// A new command word is taken while the last result word still waits at the
// output. Equal deadlines fire in insertion order; a deadline equal to the
// current time has not expired.
`include "sorted_timer_event_queue_core_defines.svh"

module sorted_timer_event_queue_core #(
    parameter int TIMERS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // amount_usec[31:0], deadline_usec[95:32], event_tag[127:96],
    // cancel_handle[131:128], zero pad[135:132]
    input  logic [stq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]                     s_axis_tuser,
    // result words
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // ok[0], slot_handle[4:1], fired_tag[36:5], wait_usec[100:37], zero pad[103:101]
    output logic [stq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W = $clog2(TIMERS + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FREE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // command fields held for the whole command
    logic [stq_pkg::TIME_W-1:0]   deadline_reg, deadline_next;
    logic [stq_pkg::TAG_W-1:0]    tag_reg, tag_next;

    // architectural state
    logic [TIMERS-1:0]            valid_reg, valid_next;
    logic [stq_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [stq_pkg::ORDER_W-1:0]  insert_count_reg, insert_count_next;

    // scan state
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         found_reg, found_next;
    logic [stq_pkg::TIME_W-1:0]   best_d_reg, best_d_next;
    logic [stq_pkg::ORDER_W-1:0]  best_age_reg, best_age_next;
    logic [stq_pkg::TAG_W-1:0]    best_tag_reg, best_tag_next;
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;

    // pending result and output register
    stq_pkg::res_t                res_reg, res_next;
    logic                         rescan_reg, rescan_next;
    logic                         out_valid_reg, out_valid_next;
    stq_pkg::res_t                out_res_reg, out_res_next;

    // RAM ports
    logic                         ram_wr_en;
    logic [IDX_W-1:0]             ram_wr_addr;
    logic [stq_pkg::SLOT_W-1:0]   ram_wr_data;
    logic                         ram_rd_en;
    logic [IDX_W-1:0]             ram_rd_addr;
    logic [stq_pkg::SLOT_W-1:0]   ram_rd_data;

    // input field views
    logic [2:0]                    in_cmd;
    logic [stq_pkg::AMOUNT_W-1:0]  in_amount;
    logic [stq_pkg::TIME_W-1:0]    in_deadline;
    logic [stq_pkg::TAG_W-1:0]     in_tag;
    logic [stq_pkg::HANDLE_W-1:0]  in_handle;

    // scan helpers
    logic [IDX_W-1:0]              cnt_idx;
    logic                          cnt_done;
    logic [stq_pkg::TIME_W-1:0]    rd_deadline;
    logic [stq_pkg::TAG_W-1:0]     rd_tag;
    logic [stq_pkg::ORDER_W-1:0]   rd_age;
    logic                          rd_better;
    logic                          out_free;
    logic                          in_accept;
    logic                          fire;

    assign in_amount   = s_axis_tdata[31:0];
    assign in_deadline = s_axis_tdata[95:32];
    assign in_tag      = s_axis_tdata[127:96];
    assign in_handle   = s_axis_tdata[131:128];
    assign in_cmd      = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign cnt_idx  = cnt_reg[IDX_W-1:0];
    assign cnt_done = (cnt_reg == CNT_W'(TIMERS));

    // compare of the word read back against the best so far
    assign rd_deadline = ram_rd_data[stq_pkg::TIME_W-1:0];
    assign rd_tag      = ram_rd_data[stq_pkg::TIME_W +: stq_pkg::TAG_W];
    assign rd_age      = insert_count_reg
                       - ram_rd_data[stq_pkg::TIME_W + stq_pkg::TAG_W +: stq_pkg::ORDER_W];
    assign rd_better   = !found_reg || (rd_deadline < best_d_reg)
                       || ((rd_deadline == best_d_reg) && (rd_age > best_age_reg));

    // earliest entry has expired
    assign fire = found_reg && (best_d_reg < now_reg);

    // slot memory
    stq_ram #(
        .WIDTH (stq_pkg::SLOT_W),
        .DEPTH (TIMERS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // control
    always_comb
    begin
        state_next        = state_reg;
        deadline_next     = deadline_reg;
        tag_next          = tag_reg;
        valid_next        = valid_reg;
        now_next          = now_reg;
        insert_count_next = insert_count_reg;
        cnt_next          = cnt_reg;
        rd_pend_next      = 1'b0;
        rd_idx_next       = cnt_idx;
        found_next        = found_reg;
        best_d_next       = best_d_reg;
        best_age_next     = best_age_reg;
        best_tag_next     = best_tag_reg;
        best_idx_next     = best_idx_reg;
        res_next          = res_reg;
        rescan_next       = rescan_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_res_next      = out_res_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = cnt_idx;
        ram_wr_data       = {insert_count_reg, tag_reg, deadline_reg};
        ram_rd_en         = 1'b0;
        ram_rd_addr       = cnt_idx;

        case (state_reg)
            ST_IDLE:
            begin
                res_next        = '0;
                res_next.kind   = stq_pkg::KIND_ACK;
                res_next.last   = 1'b1;
                rescan_next     = 1'b0;
                cnt_next        = '0;
                found_next      = 1'b0;
                tag_next        = in_tag;
                if (in_cmd == stq_pkg::CMD_SET_REL)
                begin
                    deadline_next = now_reg + stq_pkg::TIME_W'(in_amount);
                end
                else
                begin
                    deadline_next = in_deadline;
                end
                if (in_accept)
                begin
                    case (in_cmd)
                        stq_pkg::CMD_ADVANCE:
                        begin
                            now_next    = now_reg + stq_pkg::TIME_W'(in_amount);
                            res_next.ok = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        stq_pkg::CMD_SET_REL, stq_pkg::CMD_SET_ABS:
                        begin
                            state_next = ST_FREE;
                        end
                        stq_pkg::CMD_CANCEL:
                        begin
                            if ((32'(in_handle) < TIMERS) && valid_reg[IDX_W'(in_handle)])
                            begin
                                valid_next[IDX_W'(in_handle)] = 1'b0;
                                res_next.ok = 1'b1;
                            end
                            state_next = ST_EMIT;
                        end
                        stq_pkg::CMD_RUN:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // lowest free slot, one valid bit a cycle
            ST_FREE:
            begin
                if (cnt_done)
                begin
                    state_next = ST_EMIT;
                end
                else if (!valid_reg[cnt_idx])
                begin
                    ram_wr_en           = 1'b1;
                    valid_next[cnt_idx] = 1'b1;
                    insert_count_next   = insert_count_reg + 1'b1;
                    res_next.ok         = 1'b1;
                    res_next.handle     = stq_pkg::HANDLE_W'(cnt_idx);
                    state_next          = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // read every slot, keep the earliest valid one
            ST_SCAN:
            begin
                if (!cnt_done)
                begin
                    ram_rd_en    = 1'b1;
                    rd_pend_next = valid_reg[cnt_idx];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
                if (rd_pend_reg && rd_better)
                begin
                    found_next    = 1'b1;
                    best_d_next   = rd_deadline;
                    best_age_next = rd_age;
                    best_tag_next = rd_tag;
                    best_idx_next = rd_idx_reg;
                end
            end

            // fire the earliest entry or close the run with a summary
            ST_DECIDE:
            begin
                res_next = '0;
                if (fire)
                begin
                    res_next.kind = stq_pkg::KIND_EVENT;
                    res_next.tag  = best_tag_reg;
                    valid_next[best_idx_reg] = 1'b0;
                    rescan_next   = 1'b1;
                end
                else
                begin
                    res_next.kind = stq_pkg::KIND_SUMMARY;
                    res_next.last = 1'b1;
                    if (found_reg)
                    begin
                        res_next.ok        = 1'b1;
                        res_next.wait_usec = best_d_reg - now_reg;
                    end
                    rescan_next = 1'b0;
                end
                state_next = ST_EMIT;
            end

            // hand the result to the output register
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    cnt_next       = '0;
                    found_next     = 1'b0;
                    if (rescan_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            now_reg          <= '0;
            insert_count_reg <= '0;
            cnt_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            found_reg        <= 1'b0;
            rescan_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            now_reg          <= now_next;
            insert_count_reg <= insert_count_next;
            cnt_reg          <= cnt_next;
            rd_pend_reg      <= rd_pend_next;
            found_reg        <= found_next;
            rescan_reg       <= rescan_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
        rd_idx_reg   <= rd_idx_next;
        best_d_reg   <= best_d_next;
        best_age_reg <= best_age_next;
        best_tag_reg <= best_tag_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
    end

    // output word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {3'b000, out_res_reg.wait_usec, out_res_reg.tag,
                            out_res_reg.handle, out_res_reg.ok};

    // checks
    `STQ_ASSERT_NOW(a_event_not_last, m_axis_tvalid && (m_axis_tuser == stq_pkg::KIND_EVENT), !m_axis_tlast, "expired event marked as last word")
    `STQ_ASSERT_NEXT(a_fired_slot_freed, (state_reg == ST_DECIDE) && fire, !valid_reg[$past(best_idx_reg)], "fired slot still valid")
    `STQ_ASSERT_NOW(a_count_only_on_store, insert_count_reg != $past(insert_count_reg), $past(state_reg == ST_FREE), "insert count moved outside a set")

endmodule

// ===== sv/stq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/sorted_timer_event_queue_core_test.sv =====
// Sorted timer event queue testbench: directed and random traffic checked against a slot-table predictor.
`timescale 1ns / 100ps

module sorted_timer_event_queue_core_test;

    localparam int TIMERS         = 16;
    localparam int RANDOM_WORDS   = 200;
    localparam int MAX_SHOWN      = 10;
    localparam int HOLD_AT_RESULT = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;

    // command codes the block does not implement
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_MID   = 3'd6;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [stq_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [2:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [stq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    // timer table mirror and queue of expected result words
    class timer_scoreboard;
        bit            busy[TIMERS];
        logic [63:0]   due[TIMERS];
        logic [31:0]   label[TIMERS];
        logic [31:0]   seq_no[TIMERS];
        logic [63:0]   now;
        logic [31:0]   seq_count;
        stq_pkg::res_t expected_q[$];
        int            mismatches;
        int            fired;
        int            runs;
        int            set_rejects;

        function new();
            for (int i = 0; i < TIMERS; i++)
                busy[i] = 1'b0;
            now         = '0;
            seq_count   = '0;
            mismatches  = 0;
            fired       = 0;
            runs        = 0;
            set_rejects = 0;
        endfunction

        function int free_slots();
            int n;
            n = 0;
            for (int i = 0; i < TIMERS; i++)
                if (!busy[i])
                    n++;
            return n;
        endfunction

        // random occupied slot, or -1 when the table is empty
        function int pick_busy();
            int start;
            int idx;
            start = $urandom_range(0, TIMERS - 1);
            for (int i = 0; i < TIMERS; i++)
            begin
                idx = (start + i) % TIMERS;
                if (busy[idx])
                    return idx;
            end
            return -1;
        endfunction

        function void push(logic [1:0] kind, logic ok, logic [3:0] handle,
                           logic [31:0] tag, logic [63:0] wait_usec, logic last);
            stq_pkg::res_t r;
            r.kind      = kind;
            r.ok        = ok;
            r.handle    = handle;
            r.tag       = tag;
            r.wait_usec = wait_usec;
            r.last      = last;
            expected_q.push_back(r);
        endfunction

        // earliest deadline; ties go to the older insertion
        function int earliest_slot();
            int          best;
            logic [31:0] age_i;
            logic [31:0] age_b;
            best = -1;
            for (int i = 0; i < TIMERS; i++)
            begin
                if (!busy[i])
                    continue;
                if (best < 0 || due[i] < due[best])
                    best = i;
                else if (due[i] == due[best])
                begin
                    age_i = seq_count - seq_no[i];
                    age_b = seq_count - seq_no[best];
                    if (age_i > age_b)
                        best = i;
                end
            end
            return best;
        endfunction

        // accepted command word: update the mirror, queue its results
        function void note_word(logic [2:0] cmd, logic [31:0] amount, logic [63:0] deadline,
                                logic [31:0] tag, logic [3:0] handle);
            int s;
            case (cmd)
                stq_pkg::CMD_ADVANCE:
                begin
                    now = now + {32'd0, amount};
                    push(stq_pkg::KIND_ACK, 1'b1, 4'd0, 32'd0, 64'd0, 1'b1);
                end
                stq_pkg::CMD_SET_REL, stq_pkg::CMD_SET_ABS:
                begin
                    s = -1;
                    for (int i = 0; i < TIMERS; i++)
                        if (!busy[i] && s < 0)
                            s = i;
                    if (s < 0)
                    begin
                        set_rejects++;
                        push(stq_pkg::KIND_ACK, 1'b0, 4'd0, 32'd0, 64'd0, 1'b1);
                    end
                    else
                    begin
                        busy[s]   = 1'b1;
                        due[s]    = (cmd == stq_pkg::CMD_SET_REL) ? now + {32'd0, amount}
                                                                  : deadline;
                        label[s]  = tag;
                        seq_no[s] = seq_count;
                        seq_count = seq_count + 32'd1;
                        push(stq_pkg::KIND_ACK, 1'b1, 4'(s), 32'd0, 64'd0, 1'b1);
                    end
                end
                stq_pkg::CMD_CANCEL:
                begin
                    if (busy[handle])
                    begin
                        busy[handle] = 1'b0;
                        push(stq_pkg::KIND_ACK, 1'b1, 4'd0, 32'd0, 64'd0, 1'b1);
                    end
                    else
                        push(stq_pkg::KIND_ACK, 1'b0, 4'd0, 32'd0, 64'd0, 1'b1);
                end
                stq_pkg::CMD_RUN:
                begin
                    runs++;
                    s = earliest_slot();
                    // strictly before now fires; equal to now stays
                    while (s >= 0 && due[s] < now)
                    begin
                        push(stq_pkg::KIND_EVENT, 1'b0, 4'd0, label[s], 64'd0, 1'b0);
                        busy[s] = 1'b0;
                        fired++;
                        s = earliest_slot();
                    end
                    if (s < 0)
                        push(stq_pkg::KIND_SUMMARY, 1'b0, 4'd0, 32'd0, 64'd0, 1'b1);
                    else
                        push(stq_pkg::KIND_SUMMARY, 1'b1, 4'd0, 32'd0, due[s] - now, 1'b1);
                end
                default:
                    push(stq_pkg::KIND_ACK, 1'b0, 4'd0, 32'd0, 64'd0, 1'b1);
            endcase
        endfunction

        // accepted result word against the oldest expectation
        function void check_word(stq_pkg::res_t got);
            stq_pkg::res_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%t unexpected result word: kind=%0d ok=%0d handle=%0d tag=%h wait=%h last=%0d",
                             $realtime, got.kind, got.ok, got.handle, got.tag, got.wait_usec, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.ok !== want.ok || got.handle !== want.handle ||
                got.tag !== want.tag || got.wait_usec !== want.wait_usec ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("%t result mismatch", $realtime);
                    $display("  expected kind=%0d ok=%0d handle=%0d tag=%h wait=%h last=%0d",
                             want.kind, want.ok, want.handle, want.tag, want.wait_usec, want.last);
                    $display("  actual   kind=%0d ok=%0d handle=%0d tag=%h wait=%h last=%0d",
                             got.kind, got.ok, got.handle, got.tag, got.wait_usec, got.last);
                end
            end
        endfunction
    endclass

    timer_scoreboard sb;
    int              words_sent;
    int              results_seen;

    sorted_timer_event_queue_core #(
        .TIMERS(TIMERS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // offer one command word after a random gap, wait for acceptance
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] amount,
                             input logic [63:0] deadline, input logic [31:0] tag,
                             input logic [3:0] handle);
        int gap;
        bit ready_seen;
        gap = $urandom_range(0, 8);
        if (((words_sent / 32) % 4) == 3)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, handle, tag, deadline, amount};
        s_axis_tuser  <= cmd;
        // ready is sampled mid-cycle, ahead of the edge that takes the word
        ready_seen = 1'b0;
        while (!ready_seen)
        begin
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end
        sb.note_word(cmd, amount, deadline, tag, handle);
        words_sent++;
    endtask

    // one command with random content shaped to land near the current time
    task automatic send_random(input logic [2:0] cmd);
        logic [31:0] amount;
        logic [63:0] deadline;
        logic [31:0] tag;
        logic [3:0]  handle;
        int          pick;
        int          slot;
        amount   = $urandom();
        deadline = rand64();
        tag      = $urandom();
        handle   = 4'($urandom_range(0, 15));
        pick     = $urandom_range(0, 19);
        case (cmd)
            stq_pkg::CMD_ADVANCE:
            begin
                if (pick < 14)
                    amount = $urandom_range(0, 100);
                else if (pick < 17)
                    amount = $urandom_range(0, 1000);
            end
            stq_pkg::CMD_SET_REL:
            begin
                if (pick < 18)
                    amount = $urandom_range(0, 300);
            end
            stq_pkg::CMD_SET_ABS:
            begin
                if (pick < 12)
                begin
                    if (sb.now >= 64'd50)
                        deadline = sb.now - 64'd50 + 64'($urandom_range(0, 350));
                    else
                        deadline = 64'($urandom_range(0, 350));
                end
                else if (pick < 15)
                    deadline = sb.now;
                else if (pick < 17)
                    deadline = 64'($urandom_range(0, 20));
                else if (pick < 18)
                    deadline = '0;
            end
            stq_pkg::CMD_CANCEL:
            begin
                slot = sb.pick_busy();
                if (pick < 14 && slot >= 0)
                    handle = 4'(slot);
            end
            default:
                ;
        endcase
        send_word(cmd, amount, deadline, tag, handle);
    endtask

    // result side: random stall per word, one long hold-off
    initial
    begin
        int            stall;
        bit            held;
        bit            seen;
        stq_pkg::res_t got;
        stall         = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            // handshake and word are sampled mid-cycle, ahead of the edge
            @(negedge clk);
            seen = rst_n && m_axis_tvalid && m_axis_tready;
            if (seen)
            begin
                got.kind      = m_axis_tuser;
                got.ok        = m_axis_tdata[0];
                got.handle    = m_axis_tdata[4:1];
                got.tag       = m_axis_tdata[36:5];
                got.wait_usec = m_axis_tdata[100:37];
                got.last      = m_axis_tlast;
            end
            @(posedge clk);
            if (seen)
            begin
                sb.check_word(got);
                results_seen++;
                stall = $urandom_range(0, 8);
                if (((results_seen / 40) % 4) == 3)
                    stall = 0;
                if (!held && results_seen == HOLD_AT_RESULT)
                begin
                    stall = HOLD_CYCLES;
                    held  = 1'b1;
                end
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        int start;
        int pick;
        int n;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = stq_pkg::CMD_ADVANCE;
        words_sent    = 0;
        results_seen  = 0;
        sb            = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, free cancel, unused codes
        send_word(stq_pkg::CMD_RUN, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_CANCEL, $urandom(), rand64(), $urandom(), 4'hF);
        send_word(CMD_RESERVED_FIRST, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));
        send_word(CMD_RESERVED_LAST, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));
        // deadline equal to now is not expired
        send_word(stq_pkg::CMD_SET_ABS, $urandom(), 64'd0, 32'h0000_0000,
                  4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_RUN, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));
        // extreme delay and deadline
        send_word(stq_pkg::CMD_SET_REL, 32'hFFFF_FFFF, rand64(), 32'hFFFF_FFFF,
                  4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_SET_ABS, $urandom(), 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A, 4'd0);
        // equal deadlines, one relative and one absolute
        send_word(stq_pkg::CMD_SET_REL, 32'd10, rand64(), 32'h1111_1111,
                  4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_SET_ABS, $urandom(), 64'd10, 32'h2222_2222,
                  4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_ADVANCE, 32'd0, rand64(), $urandom(), 4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_ADVANCE, 32'd11, rand64(), $urandom(), 4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_RUN, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));
        // cancel a live slot, then the same slot again
        send_word(stq_pkg::CMD_CANCEL, $urandom(), rand64(), $urandom(), 4'd2);
        send_word(stq_pkg::CMD_CANCEL, $urandom(), rand64(), $urandom(), 4'd2);
        send_word(stq_pkg::CMD_ADVANCE, 32'hFFFF_FFFF, rand64(), $urandom(),
                  4'($urandom_range(0, 15)));
        send_word(stq_pkg::CMD_RUN, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));
        send_word(CMD_RESERVED_MID, $urandom(), rand64(), $urandom(), 4'($urandom_range(0, 15)));

        // random traffic: fill bursts, cancel sweeps and single commands
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // fill past full, then let a batch expire
                n = sb.free_slots() + 1;
                repeat (n)
                    send_random(($urandom_range(0, 2) == 0) ? stq_pkg::CMD_SET_ABS
                                                            : stq_pkg::CMD_SET_REL);
                send_random(stq_pkg::CMD_ADVANCE);
                send_random(stq_pkg::CMD_RUN);
            end
            else if (pick < 12)
            begin
                for (int h = 0; h < TIMERS; h++)
                    send_word(stq_pkg::CMD_CANCEL, $urandom(), rand64(), $urandom(), 4'(h));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    send_random(stq_pkg::CMD_ADVANCE);
                else if (pick < 45)
                    send_random(stq_pkg::CMD_SET_REL);
                else if (pick < 58)
                    send_random(stq_pkg::CMD_SET_ABS);
                else if (pick < 73)
                    send_random(stq_pkg::CMD_CANCEL);
                else if (pick < 95)
                    send_random(stq_pkg::CMD_RUN);
                else
                    send_random(3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST)));
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain and settle
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            sb.mismatches++;
            $display("%0d expected result words never arrived", sb.expected_q.size());
        end

        $display("covered %0d command words and %0d result words: %0d runs, %0d timers fired",
                 words_sent, results_seen, sb.runs, sb.fired);
        $display("%0d sets rejected on a full table, %0d mismatches",
                 sb.set_rejects, sb.mismatches);
        if (sb.mismatches == 0)
            $display("sorted_timer_event_queue_core verification clean");
        else
            $display("sorted_timer_event_queue_core verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("sorted_timer_event_queue_core verification failed");
        $finish;
    end

endmodule
